/* rtl/pgn_pkg.sv */
// ----------------------------------------------------------------------------
// Polar Gaussian noise package
// Shared widths, constants and transfer types of the polar Gaussian noise
// generator.
// ----------------------------------------------------------------------------
package pgn_pkg;

	localparam int UNIFORM_BITS  = 24;
	localparam int OUT_FRAC_BITS = 16;
	localparam int OUT_WIDTH     = OUT_FRAC_BITS + 4;

	localparam logic [61:0] ONE_Q60     = 62'd1 << 60;
	localparam logic [61:0] S_MIN_Q60   = 62'd11529215047;
	localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

	typedef struct packed {
		logic [UNIFORM_BITS-1:0] uniform_a;
		logic [UNIFORM_BITS-1:0] uniform_b;
	} sample_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] noise_value;
		logic                        last;
	} result_t;

endpackage

/* rtl/polar_gaussian_noise_top.sv */
// ----------------------------------------------------------------------------
// Polar Gaussian noise generator
// Turns pairs of uniform fractions into pairs of standard normal variates
// with the Marsaglia polar method in fixed point.
// ----------------------------------------------------------------------------
// Usage:
// A pair of uniform samples is transferred on a rising edge where start is
// high and busy is low. Busy is set by each transfer and is high in the cycle after it, so
// the block takes no new pair while busy is high.
// A pair whose squared radius is not below one, or is too close to zero, is
// dropped and gives no result. Every other pair gives two results, each shown
// for one cycle with strobe high; the second carries last.
// The first result leaves the last pipeline stage onto the ports; the second
// follows in the next cycle. The pipeline has 30 logarithm steps, 31
// square-root steps and 32 divider steps, one per stage, plus twelve stages
// of setup, scaling and output.
// The receiver cannot stall; the input spacing that busy enforces keeps the
// output free for both results of every pair.
// Reset clears all valid bits and the output strobe; items in flight are lost.
// ----------------------------------------------------------------------------
module polar_gaussian_noise_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pgn_pkg::sample_t sample,
	output logic             strobe,
	output pgn_pkg::result_t result
);

	localparam int UB        = pgn_pkg::UNIFORM_BITS;
	localparam int OW        = pgn_pkg::OUT_WIDTH;
	localparam int LOG_STEPS = 30;
	localparam int RT_STEPS  = 31;
	localparam int DIV_STEPS = 32;
	localparam int RND_SHIFT = 28 - pgn_pkg::OUT_FRAC_BITS;
	localparam logic [32:0] RND_HALF = 33'd1 << (RND_SHIFT - 1);
	localparam logic [32:0] PMAX     = (33'd1 << (OW - 1)) - 33'd1;
	localparam logic [32:0] NMAX     = 33'd1 << (OW - 1);
	localparam logic [30:0] ONE_Q30  = 31'd1 << 30;

	typedef struct packed {
		logic        neg_a;
		logic        neg_b;
		logic [30:0] mag_a;
		logic [30:0] mag_b;
	} side_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [30:0] root;
		logic [61:0] x;
	} rt_t;

	typedef struct packed {
		logic [29:0] rem;
		logic [31:0] sh;
	} dv_t;

	function automatic rt_t rt_step(rt_t a);
		rt_t         r;
		logic [33:0] cur;
		logic [33:0] trial;
		cur   = {a.rem[31:0], a.x[61:60]};
		trial = {1'b0, a.root, 2'b01};
		if (cur >= trial) begin
			r.rem  = cur - trial;
			r.root = {a.root[29:0], 1'b1};
		end else begin
			r.rem  = cur;
			r.root = {a.root[29:0], 1'b0};
		end
		r.x = {a.x[59:0], 2'b00};
		return r;
	endfunction

	function automatic dv_t dv_step(dv_t a, logic [29:0] d);
		dv_t         r;
		logic [30:0] cur;
		logic        ge;
		cur  = {a.rem, a.sh[31]};
		ge   = (cur >= {1'b0, d});
		r.rem = ge ? 30'(cur - {1'b0, d}) : cur[29:0];
		r.sh  = {a.sh[30:0], ge};
		return r;
	endfunction

	function automatic logic [OW-1:0] make_out(logic neg, logic ovf, logic [31:0] qv);
		logic [31:0] q;
		logic [32:0] r;
		q = ovf ? '1 : qv;
		r = (33'(q) + RND_HALF) >> RND_SHIFT;
		if (neg) begin
			if (r > NMAX) begin
				r = NMAX;
			end
			return OW'(33'd0 - r);
		end
		if (r > PMAX) begin
			r = PMAX;
		end
		return OW'(r);
	endfunction

	// Input transfer and conversion to sign bits and unsigned Q1.30 magnitudes.
	logic        acc;
	logic [29:0] a30_a, a30_b;
	logic [30:0] two_a, two_b;
	logic        busy_q;

	assign acc  = start & ~busy_q;
	assign busy = busy_q;

	generate
		if (UB <= 30) begin : g_widen
			assign a30_a = 30'(sample.uniform_a) << (30 - UB);
			assign a30_b = 30'(sample.uniform_b) << (30 - UB);
		end else begin : g_narrow
			assign a30_a = 30'(sample.uniform_a >> (UB - 30));
			assign a30_b = 30'(sample.uniform_b >> (UB - 30));
		end
	endgenerate

	assign two_a = {a30_a, 1'b0};
	assign two_b = {a30_b, 1'b0};

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	side_t       side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [61:0] sq_a_s2, sq_b_s2, s_s3, s_s4;
	logic [5:0]  p_s4;
	logic [30:0] m_s5;
	logic [4:0]  e_s5;
	logic [59:0] s_s5;
	logic        rej;
	logic [5:0]  lead;

	always_comb begin
		lead = '0;
		for (int i = 0; i < 60; i++) begin
			if (s_s3[i]) begin
				lead = 6'(i);
			end
		end
	end

	assign rej = (s_s3 >= pgn_pkg::ONE_Q60) || (s_s3 < pgn_pkg::S_MIN_Q60);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
		end else begin
			busy_q <= acc;
			v_s1   <= acc;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3 & ~rej;
			v_s5   <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.neg_a <= ~a30_a[29];
		side_s1.neg_b <= ~a30_b[29];
		side_s1.mag_a <= a30_a[29] ? (two_a - ONE_Q30) : (ONE_Q30 - two_a);
		side_s1.mag_b <= a30_b[29] ? (two_b - ONE_Q30) : (ONE_Q30 - two_b);
		side_s2 <= side_s1;
		sq_a_s2 <= 62'(side_s1.mag_a) * 62'(side_s1.mag_a);
		sq_b_s2 <= 62'(side_s1.mag_b) * 62'(side_s1.mag_b);
		side_s3 <= side_s2;
		s_s3    <= sq_a_s2 + sq_b_s2;
		side_s4 <= side_s3;
		s_s4    <= s_s3;
		p_s4    <= lead;
		side_s5 <= side_s4;
		s_s5    <= s_s4[59:0];
		m_s5    <= 31'(s_s4[59:0] >> (p_s4 - 6'd30));
		e_s5    <= 5'(6'd60 - p_s4);
	end

	// Fraction of log2 of the normalised s by repeated squaring, one bit per stage.
	logic        lg_v    [0:LOG_STEPS];
	side_t       lg_side [0:LOG_STEPS];
	logic [30:0] lg_m    [0:LOG_STEPS];
	logic [29:0] lg_frac [0:LOG_STEPS];
	logic [4:0]  lg_e    [0:LOG_STEPS];
	logic [59:0] lg_s    [0:LOG_STEPS];

	assign lg_v[0]    = v_s5;
	assign lg_side[0] = side_s5;
	assign lg_m[0]    = m_s5;
	assign lg_frac[0] = '0;
	assign lg_e[0]    = e_s5;
	assign lg_s[0]    = s_s5;

	generate
		for (genvar k = 1; k <= LOG_STEPS; k++) begin : g_log
			logic [61:0] sq;
			logic [31:0] t;
			assign sq = 62'(lg_m[k-1]) * 62'(lg_m[k-1]);
			assign t  = sq[61:30];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					lg_v[k] <= 1'b0;
				end else begin
					lg_v[k] <= lg_v[k-1];
				end
			end
			always_ff @(posedge clk) begin
				lg_m[k]    <= t[31] ? t[31:1] : t[30:0];
				lg_frac[k] <= {lg_frac[k-1][28:0], t[31]};
				lg_e[k]    <= lg_e[k-1];
				lg_s[k]    <= lg_s[k-1];
				lg_side[k] <= lg_side[k-1];
			end
		end
	endgenerate

	// w = -2 ln s from -log2(s).
	logic        v_s6, v_s7, v_s8;
	side_t       side_s6, side_s7, side_s8;
	logic [59:0] s_s6, s_s7, s_s8;
	logic [34:0] lq_s6;
	logic [35:0] pi_s7;
	logic [30:0] pf_s7;
	logic [36:0] w_s8;
	logic [60:0] pf_full;

	assign pf_full = 61'(lq_s6[29:0]) * 61'(pgn_pkg::TWO_LN2_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s6 <= lg_v[LOG_STEPS];
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		side_s6 <= lg_side[LOG_STEPS];
		s_s6    <= lg_s[LOG_STEPS];
		lq_s6   <= {lg_e[LOG_STEPS], 30'd0} - {5'd0, lg_frac[LOG_STEPS]};
		side_s7 <= side_s6;
		s_s7    <= s_s6;
		pi_s7   <= 36'(lq_s6[34:30]) * 36'(pgn_pkg::TWO_LN2_Q30);
		pf_s7   <= pf_full[60:30];
		side_s8 <= side_s7;
		s_s8    <= s_s7;
		w_s8    <= 37'(pi_s7) + 37'(pf_s7);
	end

	// Two square roots, one result bit per stage.
	logic  rt_v    [0:RT_STEPS];
	side_t rt_side [0:RT_STEPS];
	rt_t   rt_w    [0:RT_STEPS];
	rt_t   rt_s    [0:RT_STEPS];

	assign rt_v[0]    = v_s8;
	assign rt_side[0] = side_s8;
	assign rt_w[0]    = '{rem: '0, root: '0, x: {w_s8[35:0], 26'd0}};
	assign rt_s[0]    = '{rem: '0, root: '0, x: {2'b00, s_s8}};

	generate
		for (genvar k = 1; k <= RT_STEPS; k++) begin : g_rt
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					rt_v[k] <= 1'b0;
				end else begin
					rt_v[k] <= rt_v[k-1];
				end
			end
			always_ff @(posedge clk) begin
				rt_w[k]    <= rt_step(rt_w[k-1]);
				rt_s[k]    <= rt_step(rt_s[k-1]);
				rt_side[k] <= rt_side[k-1];
			end
		end
	endgenerate

	// Products |v| * sqrt(w) and divider setup.
	logic        v_s9, v_s10;
	side_t       side_s9, side_s10;
	logic [61:0] pa_s9, pb_s9;
	logic [29:0] ss_s9, ss_s10;
	logic        ovf_a_s10, ovf_b_s10;
	dv_t         da_s10, db_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s9  <= rt_v[RT_STEPS];
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		side_s9   <= rt_side[RT_STEPS];
		ss_s9     <= rt_s[RT_STEPS].root[29:0];
		pa_s9     <= 62'(rt_side[RT_STEPS].mag_a) * 62'(rt_w[RT_STEPS].root);
		pb_s9     <= 62'(rt_side[RT_STEPS].mag_b) * 62'(rt_w[RT_STEPS].root);
		side_s10  <= side_s9;
		ss_s10    <= ss_s9;
		ovf_a_s10 <= pa_s9[61:32] >= ss_s9;
		ovf_b_s10 <= pb_s9[61:32] >= ss_s9;
		da_s10    <= '{rem: pa_s9[61:32], sh: pa_s9[31:0]};
		db_s10    <= '{rem: pb_s9[61:32], sh: pb_s9[31:0]};
	end

	// Restoring division by sqrt(s), one quotient bit per stage.
	logic        dv_v     [0:DIV_STEPS];
	logic [1:0]  dv_neg   [0:DIV_STEPS];
	logic [1:0]  dv_ovf   [0:DIV_STEPS];
	logic [29:0] dv_d     [0:DIV_STEPS];
	dv_t         dv_a     [0:DIV_STEPS];
	dv_t         dv_b     [0:DIV_STEPS];

	assign dv_v[0]   = v_s10;
	assign dv_neg[0] = {side_s10.neg_a, side_s10.neg_b};
	assign dv_ovf[0] = {ovf_a_s10, ovf_b_s10};
	assign dv_d[0]   = ss_s10;
	assign dv_a[0]   = da_s10;
	assign dv_b[0]   = db_s10;

	generate
		for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v[k] <= 1'b0;
				end else begin
					dv_v[k] <= dv_v[k-1];
				end
			end
			always_ff @(posedge clk) begin
				dv_neg[k] <= dv_neg[k-1];
				dv_ovf[k] <= dv_ovf[k-1];
				dv_d[k]   <= dv_d[k-1];
				dv_a[k]   <= dv_step(dv_a[k-1], dv_d[k-1]);
				dv_b[k]   <= dv_step(dv_b[k-1], dv_d[k-1]);
			end
		end
	endgenerate

	// Rounding, saturation and the two-result output sequence.
	logic          v_s11;
	logic [OW-1:0] na_s11, nb_s11;
	logic          pend_q;
	logic [OW-1:0] hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11  <= 1'b0;
			strobe <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			v_s11 <= dv_v[DIV_STEPS];
			if (v_s11) begin
				strobe <= 1'b1;
				pend_q <= 1'b1;
			end else if (pend_q) begin
				strobe <= 1'b1;
				pend_q <= 1'b0;
			end else begin
				strobe <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		na_s11 <= make_out(dv_neg[DIV_STEPS][1], dv_ovf[DIV_STEPS][1], dv_a[DIV_STEPS].sh);
		nb_s11 <= make_out(dv_neg[DIV_STEPS][0], dv_ovf[DIV_STEPS][0], dv_b[DIV_STEPS].sh);
		if (v_s11) begin
			result.noise_value <= na_s11;
			result.last        <= 1'b0;
			hold_q             <= nb_s11;
		end else if (pend_q) begin
			result.noise_value <= hold_q;
			result.last        <= 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_first_then_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe && result.last)
		else $error("first result not followed by last");
	a_last_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> $past(strobe) && !$past(result.last))
		else $error("last result without a first one");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s11 && pend_q))
		else $error("new pair reached the output while a result was pending");
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> $past(start) && !$past(busy))
		else $error("busy without a transfer");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polar Gaussian noise generator testbench
// Drives uniform pairs with random gaps, predicts each pair's two normal
// variates in fixed point, and checks every strobed result in order.
// ----------------------------------------------------------------------------
class noise_scoreboard;
	pgn_pkg::result_t pending[$];
	int errors = 0;

	function void note_sample(pgn_pkg::sample_t smp);
		longint unsigned s, lq, w, sw, ss, frac, m;
		longint signed va, vb;
		int p;
		va = longint'({smp.uniform_a, 7'b0}) - (64'sd1 << 30);
		vb = longint'({smp.uniform_b, 7'b0}) - (64'sd1 << 30);
		s = magsq(va) + magsq(vb);
		if (s >= (64'd1 << 60) || s < 64'd11529215047)
			return;
		p = 0;
		for (int i = 0; i < 64; i++)
			if (s[i])
				p = i;
		m = s >> (p - 30);
		frac = 0;
		for (int i = 1; i <= 30; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac[30-i] = 1'b1;
			end
		end
		lq = (longint'(60 - p) << 30) - frac;
		w = (lq >> 30) * 64'd1488522236 + (((lq & 64'h3fffffff) * 64'd1488522236) >> 30);
		sw = int_sqrt(w << 26);
		ss = int_sqrt(s);
		pending.push_back(scaled(va, sw, ss, 1'b0));
		pending.push_back(scaled(vb, sw, ss, 1'b1));
	endfunction

	function longint unsigned magsq(longint signed v);
		longint unsigned a;
		a = (v < 0) ? -v : v;
		return a * a;
	endfunction

	function longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function pgn_pkg::result_t scaled(longint signed v, longint unsigned sw,
		longint unsigned ss, logic lst);
		pgn_pkg::result_t r;
		longint unsigned mag, q;
		mag = (v < 0) ? -v : v;
		q = (mag * sw) / ss;
		q = (q + (64'd1 << 11)) >> 12;
		if (v < 0) begin
			if (q > 64'd524288)
				q = 64'd524288;
			q = -q;
		end else if (q > 64'd524287) begin
			q = 64'd524287;
		end
		r.noise_value = q[19:0];
		r.last = lst;
		return r;
	endfunction

	function void check_result(pgn_pkg::result_t got);
		pgn_pkg::result_t exp_r;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		if (got.noise_value !== exp_r.noise_value) begin
			$display("%0t: noise_value expected %0d actual %0d", $time,
				exp_r.noise_value, got.noise_value);
			errors++;
		end
		if (got.last !== exp_r.last) begin
			$display("%0t: last expected %0b actual %0b", $time, exp_r.last, got.last);
			errors++;
		end
	endfunction
endclass

module testbench;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic strobe;
	pgn_pkg::sample_t sample = '0;
	pgn_pkg::result_t result;
	noise_scoreboard board = new();
	int idle_cycles = 0;
	logic timed_out = 1'b0;

	polar_gaussian_noise_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample(sample), .strobe(strobe), .result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (strobe)
			board.check_result(result);
		if ((start && !busy) || strobe)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000 && !timed_out) begin
			timed_out <= 1'b1;
			$display("FAIL polar_gaussian_noise_top");
			$finish;
		end
	end

	task automatic send_pair(logic [23:0] a, logic [23:0] b, logic hold);
		int gap;
		start <= 1'b1;
		sample <= '{uniform_a: a, uniform_b: b};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_sample(sample);
		if (hold)
			return;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [23:0] near_mid();
		return 24'(24'h800000 + $urandom_range(0, 8000) - 4000);
	endfunction

	initial begin
		logic [23:0] edges[8];
		int burst;
		edges = '{24'h000000, 24'hffffff, 24'h800000, 24'h7fffff, 24'h800001,
			24'h000001, 24'h400000, 24'hc00000};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (edges[i])
			send_pair(edges[i], edges[(i * 3 + 1) % 8], 1'b0);
		send_pair(24'h800000, 24'h800000, 1'b0);
		send_pair(24'h800000, 24'h800003, 1'b0);
		send_pair(24'h800000, 24'h8000d7, 1'b0);
		send_pair(24'h7fff29, 24'h800000, 1'b0);
		send_pair(24'h800010, 24'h7ffff0, 1'b0);
		send_pair(24'h000002, 24'h800000, 1'b0);
		send_pair(24'h5a8280, 24'h5a8280, 1'b0);
		send_pair(24'hffff00, 24'h800000, 1'b0);
		for (int n = 0; n < 1800; n++) begin
			burst = $urandom_range(0, 19);
			case ($urandom_range(0, 9))
				0: send_pair(near_mid(), near_mid(), burst < 4);
				1: send_pair(24'($urandom_range(0, 255)), 24'($urandom()), burst < 4);
				2: send_pair(24'(24'hffffff - $urandom_range(0, 255)), 24'($urandom()),
					burst < 4);
				default: send_pair(24'($urandom()), 24'($urandom()), burst < 4);
			endcase
		end
		start <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (board.errors == 0)
			$display("PASS polar_gaussian_noise_top");
		else
			$display("FAIL polar_gaussian_noise_top");
		$finish;
	end
endmodule
